// File: rtl/smbrw_pkg.sv
// ----------------------------------------------------------------------------
// smbrw_pkg
// Shared types, register indexes and the PEC helper for the SMBus read-word
// master.
// ----------------------------------------------------------------------------
package smbrw_pkg;

  // Sequencer stages; each stage is split into up to four pin segments
  typedef enum logic [3:0] {
    STG_IDLE   = 4'd0,
    STG_RSTOP  = 4'd1,
    STG_START1 = 4'd2,
    STG_TXW    = 4'd3,
    STG_TXC    = 4'd4,
    STG_START2 = 4'd5,
    STG_TXR    = 4'd6,
    STG_RXL    = 4'd7,
    STG_RXH    = 4'd8,
    STG_RXP    = 4'd9,
    STG_FSTOP  = 4'd10
  } stage_t;

  // Configuration register indexes
  localparam logic CFG_MAX_ATTEMPTS   = 1'b0;
  localparam logic CFG_TICKS_PER_UNIT = 1'b1;

  localparam logic [7:0] CRC_POLY = 8'h07;

  // Item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // CRC-8 over one byte, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/smbus_read_word_pec_master.sv
// ----------------------------------------------------------------------------
// smbus_read_word_pec_master
// Tick-driven SMBus read-word master with PEC check and retry on NACK or
// PEC mismatch.
// ----------------------------------------------------------------------------
// Output: the result of an accepted item is registered in the output register.
// Throughput: one item per cycle; the sequencer step sits between the state
//   registers and the result register, so items flow back to back while the
//   output register is empty or being drained.
// Reset: synchronous, active low; sequencer idle, pins released (high),
//   max_attempts 255, ticks_per_unit 1, output register empty.
module smbus_read_word_pec_master (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [6:0]  in_slave_addr,
  input  logic [7:0]  in_command,
  input  logic        in_sda_in,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_status,
  output logic [15:0] out_read_data,
  output logic [7:0]  out_attempts_used
);

  // Configuration registers
  logic [7:0] max_att_r;
  logic [7:0] tpu_r;

  // Sequencer state
  smbrw_pkg::stage_t stg_r, stg_nxt;
  logic [1:0]  seg_r, seg_nxt;
  logic [11:0] dly_r, dly_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shf_r, shf_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  pec_r, pec_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  att_r, att_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  // Result register
  logic        out_valid_r;
  logic        done_nxt, status_nxt;
  logic        done_r, status_r, busy_r;
  logic        oscl_r, osda_r;
  logic [15:0] rdata_r;
  logic [7:0]  oatt_r;

  // Segment entry request
  logic              ent;
  smbrw_pkg::stage_t ent_stg;
  logic [1:0]        ent_seg;
  logic [3:0]        units;
  logic [7:0]        tpu_eff;
  logic              in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign tpu_eff  = (tpu_r == 8'd0) ? 8'd1 : tpu_r;

  // One sequencer step per item
  always_comb begin
    stg_nxt    = stg_r;
    seg_nxt    = seg_r;
    dly_nxt    = dly_r;
    bit_nxt    = bit_r;
    shf_nxt    = shf_r;
    addr_nxt   = addr_r;
    cmd_nxt    = cmd_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pec_nxt    = pec_r;
    crc_nxt    = crc_r;
    att_nxt    = att_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    done_nxt   = 1'b0;
    status_nxt = 1'b0;
    ent        = 1'b0;
    ent_stg    = stg_r;
    ent_seg    = 2'd0;
    units      = 4'd0;

    if (in_mode == smbrw_pkg::MODE_START) begin
      // start request, ignored while busy
      if (stg_r == smbrw_pkg::STG_IDLE) begin
        addr_nxt = in_slave_addr;
        cmd_nxt  = in_command;
        att_nxt  = 8'd0;
        lo_nxt   = 8'd0;
        hi_nxt   = 8'd0;
        pec_nxt  = 8'd0;
        crc_nxt  = 8'd0;
        bit_nxt  = 4'd0;
        shf_nxt  = 8'd0;
        ent      = 1'b1;
        ent_stg  = smbrw_pkg::STG_RSTOP;
      end
    end else if (stg_r != smbrw_pkg::STG_IDLE) begin
      if (dly_r > 12'd1) begin
        dly_nxt = dly_r - 12'd1;
      end else begin
        dly_nxt = 12'd0;
        // end of segment
        unique case (stg_r)
          smbrw_pkg::STG_RSTOP: begin
            if (seg_r < 2'd2) begin
              ent = 1'b1; ent_seg = seg_r + 2'd1;
            end else begin
              sda_nxt = 1'b1;
              if (att_r >= max_att_r) begin
                stg_nxt    = smbrw_pkg::STG_IDLE;
                seg_nxt    = 2'd0;
                done_nxt   = 1'b1;
                status_nxt = 1'b1;
              end else begin
                att_nxt = att_r + 8'd1;
                crc_nxt = 8'd0;
                ent     = 1'b1;
                ent_stg = smbrw_pkg::STG_START1;
              end
            end
          end
          smbrw_pkg::STG_FSTOP: begin
            if (seg_r < 2'd2) begin
              ent = 1'b1; ent_seg = seg_r + 2'd1;
            end else begin
              sda_nxt = 1'b1;
              if (crc_r == pec_r) begin
                stg_nxt  = smbrw_pkg::STG_IDLE;
                seg_nxt  = 2'd0;
                done_nxt = 1'b1;
              end else begin
                ent     = 1'b1;
                ent_stg = smbrw_pkg::STG_RSTOP;
              end
            end
          end
          smbrw_pkg::STG_START1, smbrw_pkg::STG_START2: begin
            if (seg_r < 2'd3) begin
              ent = 1'b1; ent_seg = seg_r + 2'd1;
            end else begin
              shf_nxt = {addr_r, stg_r == smbrw_pkg::STG_START2};
              crc_nxt = smbrw_pkg::crc8_byte(crc_r, shf_nxt);
              bit_nxt = 4'd0;
              ent     = 1'b1;
              ent_stg = (stg_r == smbrw_pkg::STG_START1) ? smbrw_pkg::STG_TXW
                                                          : smbrw_pkg::STG_TXR;
            end
          end
          smbrw_pkg::STG_TXW, smbrw_pkg::STG_TXC, smbrw_pkg::STG_TXR: begin
            if (bit_r < 4'd8) begin
              if (seg_r < 2'd2) begin
                ent = 1'b1; ent_seg = seg_r + 2'd1;
              end else begin
                shf_nxt = {shf_r[6:0], 1'b0};
                bit_nxt = bit_r + 4'd1;
                ent     = 1'b1;
              end
            end else if (seg_r == 2'd0) begin
              // sample the slave's ACK
              shf_nxt = {7'd0, in_sda_in};
              ent     = 1'b1;
              ent_seg = 2'd1;
            end else if (shf_r[0]) begin
              ent     = 1'b1;
              ent_stg = smbrw_pkg::STG_RSTOP;
            end else if (stg_r == smbrw_pkg::STG_TXW) begin
              shf_nxt = cmd_r;
              crc_nxt = smbrw_pkg::crc8_byte(crc_r, cmd_r);
              bit_nxt = 4'd0;
              ent     = 1'b1;
              ent_stg = smbrw_pkg::STG_TXC;
            end else if (stg_r == smbrw_pkg::STG_TXC) begin
              ent     = 1'b1;
              ent_stg = smbrw_pkg::STG_START2;
            end else begin
              bit_nxt = 4'd0;
              shf_nxt = 8'd0;
              ent     = 1'b1;
              ent_stg = smbrw_pkg::STG_RXL;
            end
          end
          smbrw_pkg::STG_RXL, smbrw_pkg::STG_RXH, smbrw_pkg::STG_RXP: begin
            if (bit_r < 4'd8) begin
              if (seg_r == 2'd0) begin
                shf_nxt = {shf_r[6:0], in_sda_in};
                ent     = 1'b1;
                ent_seg = 2'd1;
              end else begin
                bit_nxt = bit_r + 4'd1;
                if (bit_nxt == 4'd8) begin
                  if (stg_r == smbrw_pkg::STG_RXL) begin
                    lo_nxt  = shf_r;
                    crc_nxt = smbrw_pkg::crc8_byte(crc_r, shf_r);
                  end else if (stg_r == smbrw_pkg::STG_RXH) begin
                    hi_nxt  = shf_r;
                    crc_nxt = smbrw_pkg::crc8_byte(crc_r, shf_r);
                  end else begin
                    pec_nxt = shf_r;
                  end
                end
                ent = 1'b1;
              end
            end else if (seg_r < 2'd2) begin
              ent = 1'b1; ent_seg = seg_r + 2'd1;
            end else begin
              bit_nxt = 4'd0;
              shf_nxt = 8'd0;
              ent     = 1'b1;
              unique case (stg_r)
                smbrw_pkg::STG_RXL: ent_stg = smbrw_pkg::STG_RXH;
                smbrw_pkg::STG_RXH: ent_stg = smbrw_pkg::STG_RXP;
                default:            ent_stg = smbrw_pkg::STG_FSTOP;
              endcase
            end
          end
          default: begin
            stg_nxt = smbrw_pkg::STG_IDLE;
            seg_nxt = 2'd0;
          end
        endcase
      end
    end

    // Segment entry: set pin levels and load the segment delay
    if (ent) begin
      stg_nxt = ent_stg;
      seg_nxt = ent_seg;
      unique case (ent_stg)
        smbrw_pkg::STG_RSTOP, smbrw_pkg::STG_FSTOP: begin
          if (ent_seg == 2'd0) begin
            scl_nxt = 1'b0; units = 4'd5;
          end else if (ent_seg == 2'd1) begin
            sda_nxt = 1'b0; units = 4'd5;
          end else begin
            scl_nxt = 1'b1; units = 4'd10;
          end
        end
        smbrw_pkg::STG_START1, smbrw_pkg::STG_START2: begin
          unique case (ent_seg)
            2'd0:    begin sda_nxt = 1'b1; units = 4'd1;  end
            2'd1:    begin scl_nxt = 1'b1; units = 4'd5;  end
            2'd2:    begin sda_nxt = 1'b0; units = 4'd10; end
            default: begin scl_nxt = 1'b0; units = 4'd2;  end
          endcase
        end
        smbrw_pkg::STG_TXW, smbrw_pkg::STG_TXC, smbrw_pkg::STG_TXR: begin
          if (bit_nxt < 4'd8) begin
            // drive a data bit
            if (ent_seg == 2'd0) begin
              sda_nxt = shf_nxt[7]; units = 4'd2;
            end else if (ent_seg == 2'd1) begin
              scl_nxt = 1'b1; units = 4'd10;
            end else begin
              scl_nxt = 1'b0; units = 4'd10;
            end
          end else if (ent_seg == 2'd0) begin
            // release for the ACK
            sda_nxt = 1'b1; scl_nxt = 1'b1; units = 4'd2;
          end else begin
            scl_nxt = 1'b0; units = 4'd4;
          end
        end
        default: begin
          if (bit_nxt < 4'd8) begin
            if (ent_seg == 2'd0) begin
              sda_nxt = 1'b1; scl_nxt = 1'b1; units = 4'd2;
            end else begin
              scl_nxt = 1'b0; units = 4'd4;
            end
          end else if (ent_seg == 2'd0) begin
            // ACK the data bytes, NACK the PEC byte
            sda_nxt = (ent_stg == smbrw_pkg::STG_RXP); units = 4'd2;
          end else if (ent_seg == 2'd1) begin
            scl_nxt = 1'b1; units = 4'd10;
          end else begin
            scl_nxt = 1'b0; units = 4'd10;
          end
        end
      endcase
      // at most 10 units of 255 ticks, fits in 12 bits
      dly_nxt = {8'd0, units} * {4'd0, tpu_eff};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r <= 8'd255;
      tpu_r     <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smbrw_pkg::CFG_MAX_ATTEMPTS:   max_att_r <= cfg_data;
        smbrw_pkg::CFG_TICKS_PER_UNIT: tpu_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= smbrw_pkg::STG_IDLE;
      seg_r  <= 2'd0;
      dly_r  <= 12'd0;
      bit_r  <= 4'd0;
      shf_r  <= 8'd0;
      addr_r <= 7'd0;
      cmd_r  <= 8'd0;
      lo_r   <= 8'd0;
      hi_r   <= 8'd0;
      pec_r  <= 8'd0;
      crc_r  <= 8'd0;
      att_r  <= 8'd0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
    end else if (in_fire) begin
      stg_r  <= stg_nxt;
      seg_r  <= seg_nxt;
      dly_r  <= dly_nxt;
      bit_r  <= bit_nxt;
      shf_r  <= shf_nxt;
      addr_r <= addr_nxt;
      cmd_r  <= cmd_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      pec_r  <= pec_nxt;
      crc_r  <= crc_nxt;
      att_r  <= att_nxt;
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      oscl_r   <= scl_nxt;
      osda_r   <= sda_nxt;
      busy_r   <= (stg_nxt != smbrw_pkg::STG_IDLE);
      done_r   <= done_nxt;
      status_r <= status_nxt;
      rdata_r  <= {hi_nxt, lo_nxt};
      oatt_r   <= att_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_out       = oscl_r;
  assign out_sda_out       = osda_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_status        = status_r;
  assign out_read_data     = rdata_r;
  assign out_attempts_used = oatt_r;

endmodule

// File: rtl/smbrw_checker.sv
// ----------------------------------------------------------------------------
// smbrw_checker
// Port-level checks for the SMBus read-word master, bound to the top level.
// ----------------------------------------------------------------------------
module smbrw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_scl_out,
  input logic        out_sda_out,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic        out_status,
  input logic [15:0] out_read_data,
  input logic [7:0]  out_attempts_used
);

  // A stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_done_res))
    else $error("result item changed while stalled");

  // A finishing item leaves the master idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // Failure status appears only with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_done_res)
    else $error("status set without done");

  // A PEC match needs at least one attempt
  a_pass_att: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && !out_status |-> out_attempts_used != 8'd0)
    else $error("success reported with no attempt");

  // Both lines are released whenever the master is idle
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_out && out_sda_out)
    else $error("bus driven while idle");

endmodule

bind smbus_read_word_pec_master smbrw_checker u_smbrw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_scl_out       (out_scl_out),
  .out_sda_out       (out_sda_out),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_status        (out_status),
  .out_read_data     (out_read_data),
  .out_attempts_used (out_attempts_used)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the tick-driven SMBus read-word master with PEC check. An
// in-bench model of the master computes the expected pin levels, status,
// read data and attempt count for each item. A slave responder built on that
// model answers the bus with ACKs, data bytes and a matching PEC, or with a
// NACK on request. The tests cover ticks while idle, a good read with starts
// while busy, a NACK that uses up the attempt limit, and the limit of zero
// attempts with zero and scaled tick units.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  // Expected output of the master for one item
  typedef struct {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic        status;
    logic [15:0] data;
    logic [7:0]  attempts;
  } master_out_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = smbrw_pkg::MODE_TICK;
  logic [6:0]  in_slave_addr = 7'd0;
  logic [7:0]  in_command = 8'd0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_status;
  logic [15:0] out_read_data;
  logic [7:0]  out_attempts_used;

  smbus_read_word_pec_master dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_slave_addr     (in_slave_addr),
    .in_command        (in_command),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_out       (out_scl_out),
    .out_sda_out       (out_sda_out),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .out_read_data     (out_read_data),
    .out_attempts_used (out_attempts_used)
  );

  // Model state of the master
  smbrw_pkg::stage_t seq_stage;
  logic [1:0]  seq_seg;
  logic [15:0] seq_delay;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_reg;
  logic [6:0]  addr_q;
  logic [7:0]  cmd_q;
  logic [7:0]  low_q;
  logic [7:0]  high_q;
  logic [7:0]  pec_q;
  logic [7:0]  crc_acc;
  logic [7:0]  attempt_cnt;
  logic        scl_q;
  logic        sda_q;
  logic [7:0]  max_att;
  logic [7:0]  tick_unit;

  // Slave responder knobs
  logic [7:0]  slv_low;
  logic [7:0]  slv_high;
  int          nack_pct = 0;
  int          stray_pct = 0;

  // Pacing
  int          send_gap_pct = 0;
  int          rcv_stall_pct = 0;

  master_out_t master_outputs_q[$];
  master_out_t head;
  int          errors = 0;
  int          cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Master model
  // ---------------------------------------------------------------------------

  // Serial CRC-8, one data bit at a time, MSB first
  function automatic logic [7:0] pec_update(input logic [7:0] acc, input logic [7:0] data);
    logic fb;
    int   i;
    for (i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? smbrw_pkg::CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic int drive_bit(input logic [1:0] seg, input logic b);
    if (seg == 2'd0) begin
      sda_q = b;
      return 2;
    end
    if (seg == 2'd1) begin
      scl_q = 1'b1;
      return 10;
    end
    scl_q = 1'b0;
    return 10;
  endfunction

  function automatic int release_bit(input logic [1:0] seg);
    if (seg == 2'd0) begin
      sda_q = 1'b1;
      scl_q = 1'b1;
      return 2;
    end
    scl_q = 1'b0;
    return 4;
  endfunction

  // Enter a segment: set its pin levels and load its length in ticks
  function automatic void enter_seg(input smbrw_pkg::stage_t st, input logic [1:0] seg);
    int units;
    int unit_ticks;
    unit_ticks = (tick_unit == 8'd0) ? 1 : int'(tick_unit);
    seq_stage = st;
    seq_seg = seg;
    case (st)
      smbrw_pkg::STG_RSTOP, smbrw_pkg::STG_FSTOP: begin
        if (seg == 2'd0) begin
          scl_q = 1'b0;
          units = 5;
        end else if (seg == 2'd1) begin
          sda_q = 1'b0;
          units = 5;
        end else begin
          scl_q = 1'b1;
          units = 10;
        end
      end
      smbrw_pkg::STG_START1, smbrw_pkg::STG_START2: begin
        if (seg == 2'd0) begin
          sda_q = 1'b1;
          units = 1;
        end else if (seg == 2'd1) begin
          scl_q = 1'b1;
          units = 5;
        end else if (seg == 2'd2) begin
          sda_q = 1'b0;
          units = 10;
        end else begin
          scl_q = 1'b0;
          units = 2;
        end
      end
      smbrw_pkg::STG_TXW, smbrw_pkg::STG_TXC, smbrw_pkg::STG_TXR:
        units = (bit_cnt < 4'd8) ? drive_bit(seg, shift_reg[7]) : release_bit(seg);
      default:
        units = (bit_cnt < 4'd8) ? release_bit(seg)
                                 : drive_bit(seg, st == smbrw_pkg::STG_RXP);
    endcase
    seq_delay = 16'(units * unit_ticks);
  endfunction

  function automatic void go_idle();
    seq_stage = smbrw_pkg::STG_IDLE;
    seq_seg = 2'd0;
    seq_delay = 16'd0;
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shift_reg = b;
    crc_acc = pec_update(crc_acc, b);
    bit_cnt = 4'd0;
  endfunction

  // End of the current segment; -1 while busy, else the final status
  function automatic int seg_end(input logic sda);
    int                r;
    smbrw_pkg::stage_t nxt;
    r = -1;
    case (seq_stage)
      smbrw_pkg::STG_RSTOP: begin
        if (seq_seg < 2'd2) enter_seg(smbrw_pkg::STG_RSTOP, seq_seg + 2'd1);
        else begin
          sda_q = 1'b1;
          if (attempt_cnt >= max_att) begin
            go_idle();
            r = 1;
          end else begin
            attempt_cnt++;
            crc_acc = 8'd0;
            enter_seg(smbrw_pkg::STG_START1, 2'd0);
          end
        end
      end
      smbrw_pkg::STG_FSTOP: begin
        if (seq_seg < 2'd2) enter_seg(smbrw_pkg::STG_FSTOP, seq_seg + 2'd1);
        else begin
          sda_q = 1'b1;
          if (crc_acc == pec_q) begin
            go_idle();
            r = 0;
          end else enter_seg(smbrw_pkg::STG_RSTOP, 2'd0);
        end
      end
      smbrw_pkg::STG_START1, smbrw_pkg::STG_START2: begin
        if (seq_seg < 2'd3) enter_seg(seq_stage, seq_seg + 2'd1);
        else if (seq_stage == smbrw_pkg::STG_START1) begin
          load_byte({addr_q, 1'b0});
          enter_seg(smbrw_pkg::STG_TXW, 2'd0);
        end else begin
          load_byte({addr_q, 1'b1});
          enter_seg(smbrw_pkg::STG_TXR, 2'd0);
        end
      end
      smbrw_pkg::STG_TXW, smbrw_pkg::STG_TXC, smbrw_pkg::STG_TXR: begin
        if (bit_cnt < 4'd8) begin
          if (seq_seg < 2'd2) enter_seg(seq_stage, seq_seg + 2'd1);
          else begin
            shift_reg = {shift_reg[6:0], 1'b0};
            bit_cnt++;
            enter_seg(seq_stage, 2'd0);
          end
        end else if (seq_seg == 2'd0) begin
          // ACK sample
          shift_reg = {7'd0, sda};
          enter_seg(seq_stage, 2'd1);
        end else if (shift_reg[0]) enter_seg(smbrw_pkg::STG_RSTOP, 2'd0);
        else if (seq_stage == smbrw_pkg::STG_TXW) begin
          load_byte(cmd_q);
          enter_seg(smbrw_pkg::STG_TXC, 2'd0);
        end else if (seq_stage == smbrw_pkg::STG_TXC) enter_seg(smbrw_pkg::STG_START2, 2'd0);
        else begin
          bit_cnt = 4'd0;
          shift_reg = 8'd0;
          enter_seg(smbrw_pkg::STG_RXL, 2'd0);
        end
      end
      smbrw_pkg::STG_RXL, smbrw_pkg::STG_RXH, smbrw_pkg::STG_RXP: begin
        if (bit_cnt < 4'd8) begin
          if (seq_seg == 2'd0) begin
            shift_reg = {shift_reg[6:0], sda};
            enter_seg(seq_stage, 2'd1);
          end else begin
            bit_cnt++;
            if (bit_cnt == 4'd8) begin
              case (seq_stage)
                smbrw_pkg::STG_RXL: begin
                  low_q = shift_reg;
                  crc_acc = pec_update(crc_acc, shift_reg);
                end
                smbrw_pkg::STG_RXH: begin
                  high_q = shift_reg;
                  crc_acc = pec_update(crc_acc, shift_reg);
                end
                default: pec_q = shift_reg;
              endcase
            end
            enter_seg(seq_stage, 2'd0);
          end
        end else if (seq_seg < 2'd2) enter_seg(seq_stage, seq_seg + 2'd1);
        else begin
          case (seq_stage)
            smbrw_pkg::STG_RXL: nxt = smbrw_pkg::STG_RXH;
            smbrw_pkg::STG_RXH: nxt = smbrw_pkg::STG_RXP;
            default:            nxt = smbrw_pkg::STG_FSTOP;
          endcase
          bit_cnt = 4'd0;
          shift_reg = 8'd0;
          enter_seg(nxt, 2'd0);
        end
      end
      default: go_idle();
    endcase
    return r;
  endfunction

  // One item through the model
  function automatic master_out_t master_step(input logic mode, input logic [6:0] addr,
                                              input logic [7:0] cmd, input logic sda);
    master_out_t o;
    logic        was_idle;
    int          r;
    was_idle = (seq_stage == smbrw_pkg::STG_IDLE);
    o.done = 1'b0;
    o.status = 1'b0;
    if (mode == smbrw_pkg::MODE_START) begin
      if (was_idle) begin
        addr_q = addr;
        cmd_q = cmd;
        attempt_cnt = 8'd0;
        low_q = 8'd0;
        high_q = 8'd0;
        pec_q = 8'd0;
        crc_acc = 8'd0;
        bit_cnt = 4'd0;
        shift_reg = 8'd0;
        enter_seg(smbrw_pkg::STG_RSTOP, 2'd0);
      end
    end else if (!was_idle) begin
      if (seq_delay > 16'd1) seq_delay--;
      else begin
        seq_delay = 16'd0;
        r = seg_end(sda);
        if (r >= 0) begin
          o.done = 1'b1;
          o.status = (r == 1);
        end
      end
    end
    o.scl = scl_q;
    o.sda = sda_q;
    o.busy = (seq_stage != smbrw_pkg::STG_IDLE);
    o.data = {high_q, low_q};
    o.attempts = attempt_cnt;
    return o;
  endfunction

  function automatic void master_reset();
    max_att = 8'd255;
    tick_unit = 8'd1;
    go_idle();
    bit_cnt = 4'd0;
    shift_reg = 8'd0;
    addr_q = 7'd0;
    cmd_q = 8'd0;
    low_q = 8'd0;
    high_q = 8'd0;
    pec_q = 8'd0;
    crc_acc = 8'd0;
    attempt_cnt = 8'd0;
    scl_q = 1'b1;
    sda_q = 1'b1;
  endfunction

  // Slave answer for the next tick; only the sampled tick matters, others are noise
  function automatic logic slave_sda();
    logic [7:0] byte_out;
    logic       b;
    b = 1'($urandom_range(0, 1));
    if (seq_delay <= 16'd1 && seq_seg == 2'd0) begin
      case (seq_stage)
        smbrw_pkg::STG_TXW, smbrw_pkg::STG_TXC, smbrw_pkg::STG_TXR:
          if (bit_cnt == 4'd8) b = ($urandom_range(0, 99) < nack_pct);
        smbrw_pkg::STG_RXL, smbrw_pkg::STG_RXH, smbrw_pkg::STG_RXP: begin
          if (bit_cnt < 4'd8) begin
            byte_out = (seq_stage == smbrw_pkg::STG_RXL) ? slv_low :
                       (seq_stage == smbrw_pkg::STG_RXH) ? slv_high : crc_acc;
            b = byte_out[3'd7 - bit_cnt[2:0]];
          end
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (master_outputs_q.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected: scl %0b sda %0b done %0b data %0h",
                 $time, out_scl_out, out_sda_out, out_done_res, out_read_data);
      end else begin
        head = master_outputs_q.pop_front();
        compare_field("scl_out", 16'(head.scl), 16'(out_scl_out));
        compare_field("sda_out", 16'(head.sda), 16'(out_sda_out));
        compare_field("busy_res", 16'(head.busy), 16'(out_busy_res));
        compare_field("done_res", 16'(head.done), 16'(out_done_res));
        compare_field("status", 16'(head.status), 16'(out_status));
        compare_field("read_data", head.data, out_read_data);
        compare_field("attempts_used", 16'(head.attempts), 16'(out_attempts_used));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one item; valid stays high on return so the next item can follow at once
  task automatic send_item(input logic mode, input logic [6:0] addr, input logic [7:0] cmd,
                           input logic sda);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_slave_addr <= addr;
    in_command <= cmd;
    in_sda_in <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    master_outputs_q.push_back(master_step(mode, addr, cmd, sda));
  endtask

  // Tick the master until the transaction ends, with the odd stray start
  task automatic finish_read();
    while (seq_stage != smbrw_pkg::STG_IDLE) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_item(smbrw_pkg::MODE_START, 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send_item(smbrw_pkg::MODE_TICK, 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), slave_sda());
    end
  endtask

  task automatic run_read(input logic [6:0] addr, input logic [7:0] cmd);
    slv_low = 8'($urandom_range(0, 255));
    slv_high = 8'($urandom_range(0, 255));
    send_item(smbrw_pkg::MODE_START, addr, cmd, 1'($urandom_range(0, 1)));
    finish_read();
  endtask

  task automatic random_read();
    run_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (master_outputs_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == smbrw_pkg::CFG_MAX_ATTEMPTS) max_att = value;
    else tick_unit = value;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks while idle change nothing, at field extremes
  task automatic test_idle_ticks();
    nack_pct = 0;
    stray_pct = 0;
    send_item(smbrw_pkg::MODE_TICK, 7'h7F, 8'hFF, 1'b1);
    send_item(smbrw_pkg::MODE_TICK, 7'h00, 8'h00, 1'b0);
  endtask

  // One full read with a matching PEC; starts while busy are ignored
  task automatic test_good_read();
    slv_low = 8'hFF;
    slv_high = 8'h00;
    send_item(smbrw_pkg::MODE_START, 7'h7F, 8'hFF, 1'b1);
    send_item(smbrw_pkg::MODE_START, 7'h00, 8'h00, 1'b0);
    stray_pct = 2;
    finish_read();
    stray_pct = 0;
  endtask

  // An address NACK restarts the attempt; with one attempt allowed it fails
  task automatic test_nack_retry();
    wait_drained();
    cfg_write(smbrw_pkg::CFG_MAX_ATTEMPTS, 8'd1);
    nack_pct = 100;
    random_read();
    nack_pct = 0;
  endtask

  // No attempts allowed: the first stop ends with failure; zero and scaled units
  task automatic test_zero_attempts();
    wait_drained();
    cfg_write(smbrw_pkg::CFG_MAX_ATTEMPTS, 8'd0);
    cfg_write(smbrw_pkg::CFG_TICKS_PER_UNIT, 8'd0);
    random_read();
    wait_drained();
    cfg_write(smbrw_pkg::CFG_TICKS_PER_UNIT, 8'd3);
    random_read();
  endtask

  initial begin
    master_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 9;
    rcv_stall_pct = 47;
    test_idle_ticks();
    test_good_read();

    send_gap_pct = 47;
    rcv_stall_pct = 9;
    test_nack_retry();

    send_gap_pct = 0;
    rcv_stall_pct = 0;
    test_zero_attempts();

    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
rtl/smbrw_pkg.sv
rtl/smbus_read_word_pec_master.sv
rtl/smbrw_checker.sv
verif/tb_top.sv
